// ----- rtl/sha512_compression_macros.svh -----
// Assertion macros used by the controller
`ifndef SHA512_COMPRESSION_MACROS_SVH
`define SHA512_COMPRESSION_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sha512_pkg.sv -----
package sha512_pkg;

    localparam int unsigned ROUNDS_DEF = 80;
    localparam int unsigned WORD_W     = 64;

    typedef logic [63:0] t_word;

    // Controller to datapath commands
    typedef struct packed {
        logic load_word;   // write message word into schedule
        logic init_chain;  // load initial hash value
        logic load_work;   // copy chain value into working variables
        logic do_round;    // run one round
        logic add_chain;   // feed forward into chain value
        logic [6:0] round; // current round
    } t_cmd;

    localparam t_word H_INIT [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam t_word ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function automatic t_word small_s0(input t_word v);
        return rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
    endfunction

    function automatic t_word small_s1(input t_word v);
        return rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
    endfunction

    function automatic t_word big_s0(input t_word v);
        return rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
    endfunction

    function automatic t_word big_s1(input t_word v);
        return rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
    endfunction

endpackage

// ----- rtl/sha512_ctrl.sv -----
`include "sha512_compression_macros.svh"

module sha512_ctrl #(
    parameter int unsigned ROUNDS = sha512_pkg::ROUNDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_start_message,
    input  logic             i_final_block,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_digest_index,
    output logic             o_last_word,
    output sha512_pkg::t_cmd o_cmd
);
    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_ADD   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_wcnt, n_wcnt;
    logic [6:0] r_rcnt, n_rcnt;
    logic [2:0] r_oidx, n_oidx;
    logic       r_final, n_final;
    logic       w_acc;

    assign o_in_ready     = (r_state == S_LOAD);
    assign w_acc          = i_in_valid && o_in_ready;
    assign o_out_valid    = (r_state == S_EMIT);
    assign o_digest_index = r_oidx;
    assign o_last_word    = (r_oidx == 3'd7);

    // Drive datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.load_word  = w_acc;
        o_cmd.init_chain = w_acc && (r_wcnt == 4'd0) && i_start_message;
        o_cmd.load_work  = w_acc && (r_wcnt == 4'd15);
        o_cmd.do_round   = (r_state == S_ROUND);
        o_cmd.add_chain  = (r_state == S_ADD);
        o_cmd.round      = r_rcnt;
    end

    // Sequence words, rounds and digest transfers
    always_comb begin
        n_state = r_state;
        n_wcnt  = r_wcnt;
        n_rcnt  = r_rcnt;
        n_oidx  = r_oidx;
        n_final = r_final;
        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    n_wcnt = r_wcnt + 4'd1;
                    if (r_wcnt == 4'd15) begin
                        n_final = i_final_block;
                        n_rcnt  = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                n_rcnt = r_rcnt + 7'd1;
                if (r_rcnt == 7'(ROUNDS - 1)) n_state = S_ADD;
            end
            S_ADD: begin
                n_oidx  = '0;
                n_state = r_final ? S_EMIT : S_LOAD;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_wcnt  <= '0;
            r_rcnt  <= '0;
            r_oidx  <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            r_rcnt  <= n_rcnt;
            r_oidx  <= n_oidx;
            r_final <= n_final;
        end
    end

    `SHA_ASSERT_IMP(a_round_range, i_clk, i_rst_n, r_state == S_ROUND, r_rcnt < 7'(ROUNDS), "round count out of range")
    `SHA_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_word, r_state == S_LOAD, "emit did not end")
    `SHA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_LOAD, !o_in_ready, "accept while busy")
endmodule

// ----- rtl/sha512_datapath.sv -----
module sha512_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha512_pkg::t_cmd  i_cmd,
    input  sha512_pkg::t_word i_message_word,
    input  logic [2:0]        i_digest_index,
    output sha512_pkg::t_word o_digest_word
);
    sha512_pkg::t_word r_h [8];
    sha512_pkg::t_word r_v [8];
    sha512_pkg::t_word r_w [16];
    sha512_pkg::t_word w_new, w_t1, w_t2, w_ch, w_maj, w_k;

    // Round logic: window slot 0 holds the current schedule word
    always_comb begin
        w_new = sha512_pkg::small_s1(r_w[14]) + r_w[9]
              + sha512_pkg::small_s0(r_w[1]) + r_w[0];
        w_k   = sha512_pkg::ROUND_K[i_cmd.round];
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1  = r_v[7] + sha512_pkg::big_s1(r_v[4]) + w_ch + w_k + r_w[0];
        w_t2  = sha512_pkg::big_s0(r_v[0]) + w_maj;
    end

    assign o_digest_word = r_h[i_digest_index];

    // Shift message words in, roll the schedule each round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_message_word;
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Update working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++)
                r_v[i] <= (i_cmd.init_chain) ? sha512_pkg::H_INIT[i] : r_h[i];
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // Chain value: reset and start load the initial value, feed forward adds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::H_INIT[i];
        end else if (i_cmd.init_chain) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::H_INIT[i];
        end else if (i_cmd.add_chain) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end
endmodule

// ----- rtl/sha512_compression.sv -----
// Channel | Direction | Handshake              | Payload
// input   | in        | i_in_valid/o_in_ready  | i_message_word, i_start_message, i_final_block
// output  | out       | o_out_valid/i_out_ready| o_digest_word, o_digest_index, o_last_word
//
// Words 1 to 16 of a block are accepted one per handshake; the sixteenth starts ROUNDS
// (80 by default) rounds on one shared round unit, then one feed-forward step.
// A final block is then followed by 8 output transfers of the digest.
// Reset is synchronous, active low, and loads the initial hash value into the
// chain value; the first word of a block with i_start_message set reloads it.
// Input is stalled in rounds, feed-forward and digest emission; output stalls hold the word.
module sha512_compression #(
    parameter int unsigned ROUNDS = sha512_pkg::ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_message_word,
    input  logic        i_start_message,
    input  logic        i_final_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_last_word
);
    sha512_pkg::t_cmd w_cmd;

    sha512_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_message (i_start_message),
        .i_final_block   (i_final_block),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_digest_index  (o_digest_index),
        .o_last_word     (o_last_word),
        .o_cmd           (w_cmd)
    );

    sha512_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_message_word (i_message_word),
        .i_digest_index (o_digest_index),
        .o_digest_word  (o_digest_word)
    );
endmodule
